>>> src/ordered_list_buffer_core_defines.svh
// assertion macros shared by the ordered list buffer rtl
`ifndef ORDERED_LIST_BUFFER_CORE_DEFINES_SVH
`define ORDERED_LIST_BUFFER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define OLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define OLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/olb_pkg.sv
// shared constants, codes and types of the ordered list buffer
`timescale 1ns / 1ps
`default_nettype none

package olb_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned CAP_W  = 8;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned ST_W   = 3;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_EDIT   = 3'd3,
    REQ_GET    = 3'd4,
    REQ_FIND   = 3'd5
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> src/olb_req_if.sv
// request channel: valid/ready handshake with the request payload
`timescale 1ns / 1ps
`default_nettype none

interface olb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [6:0]  position;
  logic [31:0] value_in;

  modport source (output valid, output req_type, output position, output value_in,
                  input ready);
  modport sink (input valid, input req_type, input position, input value_in,
                output ready);
endinterface

`default_nettype wire

>>> src/olb_rsp_if.sv
// result channel: valid/ready handshake with the result payload
`timescale 1ns / 1ps
`default_nettype none

interface olb_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_out;
  logic [5:0]  found_position;
  logic [6:0]  entry_total;
  logic [7:0]  alloc_size;

  modport source (output valid, output status, output value_out, output found_position,
                  output entry_total, output alloc_size, input ready);
  modport sink (input valid, input status, input value_out, input found_position,
                input entry_total, input alloc_size, output ready);
endinterface

`default_nettype wire

>>> src/ordered_list_buffer_core.sv
// ordered list buffer: request sequencer, count and capacity tracking, result register
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to 64 32-bit words with append, insert, delete, edit, get
// and find requests, one result per request. Requests are taken one at a time:
// req.ready is high only while the sequencer is idle. Every entry move or
// compare goes through the single read and single write port of the entry
// memory, one entry per cycle; insert and delete walk the entries behind the
// position and find walks from entry zero until a match or the last entry. The
// finished result sits in an output register, so the next request is accepted
// while it waits on rsp.ready. Entries have no reset; after reset the list is
// empty and no clearing pass is run. A write of the capacity register reloads
// the reported capacity only while the list is empty (a value of zero counts as
// one).

`include "ordered_list_buffer_core_defines.svh"

module ordered_list_buffer_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [olb_pkg::CFG_W-1:0]   cfg_wdata_i,
  olb_req_if.sink                          req,
  olb_rsp_if.source                        rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_UP,
    S_INS_WRITE,
    S_SHIFT_DN,
    S_GET,
    S_FIND,
    S_RESP
  } state_e;

  state_e                            state_q, state_d;
  olb_pkg::req_e                     req_q, req_d;
  logic [olb_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [olb_pkg::DATA_W-1:0]        val_q, val_d;
  logic [olb_pkg::ADDR_W-1:0]        idx_q, idx_d;
  logic [olb_pkg::CNT_W-1:0]         count_q, count_d;
  logic [olb_pkg::CAP_W-1:0]         cap_q, cap_d;
  olb_pkg::status_e                  res_status_q, res_status_d;
  logic [olb_pkg::DATA_W-1:0]        res_value_q, res_value_d;
  logic [olb_pkg::ADDR_W-1:0]        res_fpos_q, res_fpos_d;
  logic                              out_valid_q, out_valid_d;
  olb_pkg::status_e                  out_status_q, out_status_d;
  logic [olb_pkg::DATA_W-1:0]        out_value_q, out_value_d;
  logic [olb_pkg::ADDR_W-1:0]        out_fpos_q, out_fpos_d;
  logic [olb_pkg::CNT_W-1:0]         out_count_q, out_count_d;
  logic [olb_pkg::CAP_W-1:0]         out_cap_q, out_cap_d;

  olb_pkg::mem_req_t                 mem_req;
  logic [olb_pkg::DATA_W-1:0]        rdata;
  logic [olb_pkg::CNT_W-1:0]         count_dec;
  logic [olb_pkg::CAP_W-1:0]         cap_grown;
  logic [olb_pkg::CAP_W-1:0]         cap_half;

  olb_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  assign count_dec = count_q - olb_pkg::CNT_W'(1);
  assign cap_grown = ({1'b0, count_q} == cap_q) ? {cap_q[olb_pkg::CAP_W-2:0], 1'b0} : cap_q;
  assign cap_half  = ((cap_q >> 1) >= {1'b0, count_dec} && cap_q > olb_pkg::CAP_W'(1))
                   ? (cap_q >> 1) : cap_q;

  assign req.ready          = (state_q == S_IDLE);
  assign rsp.valid          = out_valid_q;
  assign rsp.status         = out_status_q;
  assign rsp.value_out      = out_value_q;
  assign rsp.found_position = out_fpos_q;
  assign rsp.entry_total    = out_count_q;
  assign rsp.alloc_size     = out_cap_q;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    pos_d        = pos_q;
    val_d        = val_q;
    idx_d        = idx_q;
    count_d      = count_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_fpos_d   = res_fpos_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_fpos_d   = out_fpos_q;
    out_count_d  = out_count_q;
    out_cap_d    = out_cap_q;
    mem_req      = '0;

    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    // capacity reload only counts while the list is empty
    if (cfg_we_i && count_q == '0) begin
      cap_d = (cfg_wdata_i == '0) ? olb_pkg::CAP_W'(1) : {1'b0, cfg_wdata_i};
    end

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          req_d   = olb_pkg::req_e'(req.req_type);
          pos_d   = req.position;
          val_d   = req.value_in;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = olb_pkg::ST_OK;
        res_value_d  = '0;
        res_fpos_d   = '0;
        state_d      = S_RESP;
        case (req_q)
          olb_pkg::REQ_APPEND: begin
            if (count_q == olb_pkg::FULL_COUNT) begin
              res_status_d = olb_pkg::ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_q[olb_pkg::ADDR_W-1:0];
              mem_req.wdata = val_q;
              cap_d         = cap_grown;
              count_d       = count_q + olb_pkg::CNT_W'(1);
            end
          end
          olb_pkg::REQ_INSERT: begin
            if (pos_q > count_q) begin
              res_status_d = olb_pkg::ST_BADPOS;
            end else if (count_q == olb_pkg::FULL_COUNT) begin
              res_status_d = olb_pkg::ST_FULL;
            end else begin
              cap_d   = cap_grown;
              count_d = count_q + olb_pkg::CNT_W'(1);
              if (pos_q == count_q) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_q[olb_pkg::ADDR_W-1:0];
                mem_req.wdata = val_q;
              end else begin
                // walk down from the last entry, moving each one up a slot
                mem_req.raddr = count_dec[olb_pkg::ADDR_W-1:0];
                idx_d         = count_dec[olb_pkg::ADDR_W-1:0];
                state_d       = S_SHIFT_UP;
              end
            end
          end
          olb_pkg::REQ_DELETE: begin
            if (count_q == '0) begin
              res_status_d = olb_pkg::ST_EMPTY;
            end else if (pos_q >= count_q) begin
              res_status_d = olb_pkg::ST_BADPOS;
            end else begin
              count_d = count_dec;
              cap_d   = cap_half;
              if (pos_q != count_dec) begin
                mem_req.raddr = pos_q[olb_pkg::ADDR_W-1:0] + olb_pkg::ADDR_W'(1);
                idx_d         = pos_q[olb_pkg::ADDR_W-1:0] + olb_pkg::ADDR_W'(1);
                state_d       = S_SHIFT_DN;
              end
            end
          end
          olb_pkg::REQ_EDIT: begin
            if (pos_q >= count_q) begin
              res_status_d = olb_pkg::ST_BADPOS;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = pos_q[olb_pkg::ADDR_W-1:0];
              mem_req.wdata = val_q;
            end
          end
          olb_pkg::REQ_GET: begin
            if (pos_q >= count_q) begin
              res_status_d = olb_pkg::ST_BADPOS;
            end else begin
              mem_req.raddr = pos_q[olb_pkg::ADDR_W-1:0];
              state_d       = S_GET;
            end
          end
          olb_pkg::REQ_FIND: begin
            if (count_q == '0) begin
              res_status_d = olb_pkg::ST_NOTFOUND;
            end else begin
              mem_req.raddr = '0;
              idx_d         = '0;
              state_d       = S_FIND;
            end
          end
          default: begin
            res_status_d = olb_pkg::ST_BADPOS;
          end
        endcase
      end

      S_SHIFT_UP: begin
        // rdata holds entry idx_q, read last cycle
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q + olb_pkg::ADDR_W'(1);
        mem_req.wdata = rdata;
        if (idx_q == pos_q[olb_pkg::ADDR_W-1:0]) begin
          state_d = S_INS_WRITE;
        end else begin
          mem_req.raddr = idx_q - olb_pkg::ADDR_W'(1);
          idx_d         = idx_q - olb_pkg::ADDR_W'(1);
        end
      end

      S_INS_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_q[olb_pkg::ADDR_W-1:0];
        mem_req.wdata = val_q;
        state_d       = S_RESP;
      end

      S_SHIFT_DN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q - olb_pkg::ADDR_W'(1);
        mem_req.wdata = rdata;
        // count is already decremented, so the old last entry sits at count_q
        if ({1'b0, idx_q} == count_q) begin
          state_d = S_RESP;
        end else begin
          mem_req.raddr = idx_q + olb_pkg::ADDR_W'(1);
          idx_d         = idx_q + olb_pkg::ADDR_W'(1);
        end
      end

      S_GET: begin
        res_value_d = rdata;
        state_d     = S_RESP;
      end

      S_FIND: begin
        if (rdata == val_q) begin
          res_status_d = olb_pkg::ST_OK;
          res_fpos_d   = idx_q;
          state_d      = S_RESP;
        end else if ({1'b0, idx_q} == count_dec) begin
          res_status_d = olb_pkg::ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          mem_req.raddr = idx_q + olb_pkg::ADDR_W'(1);
          idx_d         = idx_q + olb_pkg::ADDR_W'(1);
        end
      end

      S_RESP: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_fpos_d   = res_fpos_q;
          out_count_d  = count_q;
          out_cap_d    = cap_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= olb_pkg::CAP_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_fpos_q   <= res_fpos_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_fpos_q   <= out_fpos_d;
    out_count_q  <= out_count_d;
    out_cap_q    <= out_cap_d;
  end

  `OLB_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_q == S_EXEC, "accepted transaction did not start execution")
  `OLB_ASSERT_NOW(a_no_write_when_idle, state_q == S_IDLE || state_q == S_RESP, !mem_req.we, "entry write outside a request")
  `OLB_ASSERT_NOW(a_find_in_range, state_q == S_FIND, {1'b0, idx_q} < count_q, "find walked past the last entry")
  `OLB_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= olb_pkg::FULL_COUNT && cap_q != '0, "entry count or capacity out of range")

endmodule

`default_nettype wire

>>> src/olb_mem.sv
// entry storage: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module olb_mem (
  input  wire logic                         clk_i,
  input  wire olb_pkg::mem_req_t            mem_req_i,
  output logic [olb_pkg::DATA_W-1:0]        rdata_o
);

  logic [olb_pkg::DATA_W-1:0] mem_q [olb_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_o <= mem_q[mem_req_i.raddr];
  end

endmodule

`default_nettype wire

>>> tb/olb_list_checker.sv
`timescale 1ns / 1ps
// checker for the ordered list buffer: mirrors the list, predicts each result and compares it

module olb_list_checker
  import olb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  olb_req_if               req,
  olb_rsp_if               rsp,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      list_len_o,
  output int unsigned      checked_o,
  output int unsigned      full_seen_o
);

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] value;
    logic [ADDR_W-1:0] fpos;
    logic [CNT_W-1:0]  total;
    logic [CAP_W-1:0]  alloc;
  } list_result_t;

  logic [DATA_W-1:0] list_words [DEPTH];
  int unsigned       word_count;
  int unsigned       alloc_now;
  list_result_t      list_results_due [$];
  int unsigned       fails;
  int unsigned       checked;
  int unsigned       fulls;

  // mirror of one request against the list, returns the result it must produce
  function automatic list_result_t apply_list_op(logic [REQ_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] val);
    list_result_t r;
    bit           hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (kind)
      REQ_APPEND: begin
        if (word_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (word_count == alloc_now) alloc_now = alloc_now * 2;
          list_words[word_count] = val;
          word_count++;
        end
      end
      REQ_INSERT: begin
        if (pos > word_count) begin
          r.status = ST_BADPOS;
        end else if (word_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (word_count == alloc_now) alloc_now = alloc_now * 2;
          for (int unsigned i = word_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          word_count++;
        end
      end
      REQ_DELETE: begin
        if (word_count == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= word_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int unsigned i = pos; i + 1 < word_count; i++) list_words[i] = list_words[i+1];
          word_count--;
          // shrink once when half the capacity still holds everything
          if (alloc_now / 2 >= word_count && alloc_now > 1) alloc_now = alloc_now / 2;
        end
      end
      REQ_EDIT: begin
        if (pos >= word_count) r.status = ST_BADPOS;
        else list_words[pos] = val;
      end
      REQ_GET: begin
        if (pos >= word_count) r.status = ST_BADPOS;
        else r.value = list_words[pos];
      end
      REQ_FIND: begin
        r.status = ST_NOTFOUND;
        for (int unsigned i = 0; i < word_count; i++) begin
          if (!hit && list_words[i] == val) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.fpos = ADDR_W'(i);
          end
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    if (r.status == ST_FULL) fulls++;
    r.total = CNT_W'(word_count);
    r.alloc = CAP_W'(alloc_now);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      word_count = 0;
      alloc_now = 1;
      list_results_due.delete();
      fails = 0;
      checked = 0;
      fulls = 0;
    end else begin
      // a new capacity only takes hold while the list is empty
      if (cfg_we_i && word_count == 0) alloc_now = (cfg_wdata_i == '0) ? 1 : cfg_wdata_i;
      if (req.valid && req.ready) begin
        list_results_due.push_back(apply_list_op(req.req_type, req.position, req.value_in));
      end
      if (rsp.valid && rsp.ready) begin
        if (list_results_due.size() == 0) begin
          fails++;
          $display("%0t ns: result transaction with nothing expected, status %0d entries %0d",
                   $time, rsp.status, rsp.entry_total);
        end else begin
          want = list_results_due.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("value_out", want.value, rsp.value_out);
          check_field("found_position", want.fpos, rsp.found_position);
          check_field("entry_total", want.total, rsp.entry_total);
          check_field("alloc_size", want.alloc, rsp.alloc_size);
          checked++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= list_results_due.size();
    list_len_o   <= word_count;
    checked_o    <= checked;
    full_seen_o  <= fulls;
  end

endmodule

>>> tb/tb_ordered_list_buffer_core.sv
`timescale 1ns / 1ps
// testbench top for the ordered list buffer: clock, reset, request and result traffic, verdict

module tb_ordered_list_buffer_core;
  import olb_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
  localparam int unsigned MODE_FILL   = 0;
  localparam int unsigned MODE_DRAIN  = 1;
  localparam int unsigned MODE_MIX    = 2;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 178;
  localparam int unsigned HOLD_CYCLES = 200;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  olb_req_if req_ch();
  olb_rsp_if rsp_ch();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned list_len;
  int unsigned checked;
  int unsigned full_seen;
  int unsigned sent;
  bit          tx_gaps;
  bit          rx_stalls;
  bit          hold_rsp;

  ordered_list_buffer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  olb_list_checker u_list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len),
    .checked_o    (checked),
    .full_seen_o  (full_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: short random stalls, plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
        hold_rsp = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // valid stays high into the next transaction unless a gap is taken
  task automatic send_item(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] val);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.position <= pos;
    req_ch.value_in <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic wait_list_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_W-1:0]  cap_plan [PHASES];
    int unsigned       phase_mode [PHASES];
    int unsigned       op_cut [3][6];
    int unsigned       r;
    int unsigned       mode;
    int unsigned       len;
    logic [REQ_W-1:0]  kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;

    cap_plan   = '{0, 64, 127, 1, 2, 5, 32, 3, 64, 16};
    phase_mode = '{MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_FILL, MODE_DRAIN,
                   MODE_MIX, MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_FILL};
    // cumulative weights: append, insert, delete, edit, get, find, rest unused codes
    op_cut[MODE_FILL]  = '{40, 70, 78, 84, 90, 97};
    op_cut[MODE_DRAIN] = '{10, 20, 65, 75, 85, 97};
    op_cut[MODE_MIX]   = '{20, 40, 60, 72, 84, 97};

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_APPEND;
    req_ch.position <= '0;
    req_ch.value_in <= '0;
    sent      = 0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    hold_rsp  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset capacity
    send_item(REQ_GET, 7'd0, 32'h0);
    send_item(REQ_DELETE, 7'd0, 32'h0);
    send_item(REQ_EDIT, 7'd0, 32'h1);
    send_item(REQ_FIND, 7'd0, 32'h0);
    send_item(REQ_INSERT, 7'd1, 32'h2);
    send_item(REQ_APPEND, 7'd0, 32'h0000_0000);
    send_item(REQ_APPEND, 7'd127, 32'hFFFF_FFFF);
    send_item(REQ_INSERT, 7'd0, 32'hA5A5_A5A5);
    send_item(REQ_INSERT, 7'd3, 32'h5A5A_5A5A);
    send_item(REQ_INSERT, 7'd5, 32'h3);
    send_item(REQ_INSERT, 7'd127, 32'h4);
    send_item(REQ_GET, 7'd0, 32'h0);
    send_item(REQ_GET, 7'd3, 32'h0);
    send_item(REQ_GET, 7'd4, 32'h0);
    send_item(REQ_EDIT, 7'd2, 32'h0);
    send_item(REQ_FIND, 7'd127, 32'h0);
    send_item(REQ_FIND, 7'd0, 32'h1234_5678);
    send_item(REQ_DELETE, 7'd127, 32'h0);
    send_item(REQ_DELETE, 7'd1, 32'h0);
    send_item(REQ_DELETE, 7'd0, 32'h0);
    send_item(REQ_SPARE_A, 7'd0, 32'h0);
    send_item(REQ_SPARE_B, 7'd0, 32'h0);
    send_item(REQ_EDIT, 7'd127, 32'h5);
    send_item(REQ_DELETE, 7'd1, 32'h0);
    send_item(REQ_GET, 7'd0, 32'h0);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_list_idle();
      cfg_wdata_i <= cap_plan[ph];
      cfg_we_i    <= 1'b1;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      tx_gaps   = (ph < PHASES - 2) && (ph != 4);
      rx_stalls = (ph < PHASES - 2) && (ph != 5);
      if (ph == 0) hold_rsp = 1'b1;
      mode = phase_mode[ph];
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        len = list_len;
        r = $urandom_range(0, 99);
        if (r < op_cut[mode][0]) kind = REQ_APPEND;
        else if (r < op_cut[mode][1]) kind = REQ_INSERT;
        else if (r < op_cut[mode][2]) kind = REQ_DELETE;
        else if (r < op_cut[mode][3]) kind = REQ_EDIT;
        else if (r < op_cut[mode][4]) kind = REQ_GET;
        else if (r < op_cut[mode][5]) kind = REQ_FIND;
        else kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        // mostly in range, with the end, one past it and anything at all mixed in
        case ($urandom_range(0, 9))
          0:       pos = POS_W'($urandom_range(0, 127));
          1:       pos = POS_W'(len);
          2:       pos = POS_W'(len + 1);
          default: pos = (len == 0) ? '0 : POS_W'($urandom_range(0, len - 1));
        endcase
        // a small pool of values gives find something to hit
        case ($urandom_range(0, 3))
          0:       val = $urandom;
          3:       val = ~DATA_W'($urandom_range(0, 7));
          default: val = DATA_W'($urandom_range(0, 7));
        endcase
        send_item(kind, pos, val);
      end
    end

    wait_list_idle();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d requests over %0d capacity settings, %0d results checked",
             sent, PHASES + 1, checked);
    $display("%0d requests met a full list; long result hold-off and idle-free stretches run",
             full_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/olb_pkg.sv
src/olb_req_if.sv
src/olb_rsp_if.sv
src/olb_mem.sv
src/ordered_list_buffer_core.sv
tb/olb_list_checker.sv
tb/tb_ordered_list_buffer_core.sv
